// ----- rtl/core/cavesm_pkg.sv -----
// Shared types and constants for the cave-smoothing automaton.
// Used by every module under rtl/core except cavesm_cell; depends on nothing.
package cavesm_pkg;

  // Fixed widths of the stream and configuration fields
  localparam int COL_BITS      = 64;
  localparam int ROWS_IN_USE_W = 7;
  localparam int PASS_COUNT_W  = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PASS_COUNT  = 1'd1;

  // Configuration reset values
  localparam logic [ROWS_IN_USE_W-1:0] ROWS_IN_USE_RST = 7'd64;
  localparam logic [PASS_COUNT_W-1:0]  PASS_COUNT_RST  = 8'd5;

  // Alive/dead decision threshold on the neighbor count
  localparam logic [3:0] KEEP_COUNT = 4'd4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SMOOTH,
    ST_EMIT
  } cavesm_state_t;

  // What enters the tail cell of the chain on a shift
  typedef enum logic [1:0] {
    TAIL_LOAD,
    TAIL_RULE,
    TAIL_ROTATE
  } cavesm_tail_t;

  // Grid border flags for the column under update
  typedef struct packed {
    logic left_edge;
    logic right_edge;
  } cavesm_edge_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic         shift;
    cavesm_tail_t tail_sel;
    logic         store_prev;
    cavesm_edge_t edges;
    logic         out_load;
    logic         out_last;
  } cavesm_ctrl_t;

endpackage

// ----- rtl/core/cavesm_cell.sv -----
// One cell of the column chain: holds one grid column.
// Depends on nothing beyond its parameter.
module cavesm_cell #(
  parameter int ROWS = 64
) (
  input  logic            clk,
  input  logic            shift,
  input  logic [ROWS-1:0] din,
  output logic [ROWS-1:0] q
);

  // Take the neighbor's column on every shift
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

// ----- rtl/core/cavesm_rule.sv -----
// Neighbor count and 4-5 rule for one column, all rows in parallel.
// Depends on cavesm_pkg for the edge flags and threshold.
module cavesm_rule
  import cavesm_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic [ROWS-1:0] left_col,
  input  logic [ROWS-1:0] center_col,
  input  logic [ROWS-1:0] right_col,
  input  logic [ROWS-1:0] mask,
  input  cavesm_edge_t    edges,
  output logic [ROWS-1:0] new_col
);

  logic [ROWS-1:0] l_ext, c_ext, r_ext;
  logic [ROWS-1:0] l_up, l_dn, c_up, c_dn, r_up, r_dn;
  logic [3:0]      cnt [ROWS];

  // Columns outside the grid and rows above the height read as alive
  assign l_ext = edges.left_edge  ? '1 : (left_col  | ~mask);
  assign r_ext = edges.right_edge ? '1 : (right_col | ~mask);
  assign c_ext = center_col | ~mask;

  // Row neighbors: up is row y+1, down is row y-1; the border is alive
  assign l_up = {1'b1, l_ext[ROWS-1:1]};
  assign l_dn = {l_ext[ROWS-2:0], 1'b1};
  assign c_up = {1'b1, c_ext[ROWS-1:1]};
  assign c_dn = {c_ext[ROWS-2:0], 1'b1};
  assign r_up = {1'b1, r_ext[ROWS-1:1]};
  assign r_dn = {r_ext[ROWS-2:0], 1'b1};

  // Count eight neighbors per row and apply the rule
  always_comb begin
    for (int y = 0; y < ROWS; y++) begin
      cnt[y] = {3'b0, l_ext[y]} + {3'b0, l_up[y]} + {3'b0, l_dn[y]}
             + {3'b0, r_ext[y]} + {3'b0, r_up[y]} + {3'b0, r_dn[y]}
             + {3'b0, c_up[y]}  + {3'b0, c_dn[y]};
      if (cnt[y] > KEEP_COUNT) begin
        new_col[y] = mask[y];
      end else if (cnt[y] < KEEP_COUNT) begin
        new_col[y] = 1'b0;
      end else begin
        new_col[y] = center_col[y] & mask[y];
      end
    end
  end

endmodule

// ----- rtl/core/cavesm_ctrl.sv -----
// Sequencer: load, smoothing passes over the chain, then emission.
// Depends on cavesm_pkg for the state, tail select and command struct.
module cavesm_ctrl
  import cavesm_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tlast,
  output logic                    s_tready,
  input  logic [PASS_COUNT_W-1:0] pass_count,
  input  logic                    out_free,
  output cavesm_ctrl_t            ctrl,
  output cavesm_state_t           state,
  output logic [PASS_COUNT_W-1:0] passes
);

  localparam int SLOT_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_COLUMNS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_COLUMNS);

  cavesm_state_t           state_next;
  logic [SLOT_W-1:0]       slot, slot_next;
  logic [PASS_COUNT_W-1:0] passes_next;
  logic [CNT_W-1:0]        loaded, loaded_next;
  logic [CNT_W-1:0]        first_slot;
  logic [CNT_W-1:0]        slot_ext;
  logic                    in_grid;

  // Column 0 sits at slot MAX_COLUMNS - loaded; the last column at the last slot
  assign first_slot = FULL_CNT - loaded;
  assign slot_ext   = {1'b0, slot};
  assign in_grid    = slot_ext >= first_slot;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      slot   <= '0;
      passes <= '0;
      loaded <= '0;
    end else begin
      state  <= state_next;
      slot   <= slot_next;
      passes <= passes_next;
      loaded <= loaded_next;
    end
  end

  // Next state and chain commands
  always_comb begin
    state_next           = state;
    slot_next            = slot;
    passes_next          = passes;
    loaded_next          = loaded;
    s_tready             = 1'b0;
    ctrl.shift           = 1'b0;
    ctrl.tail_sel        = TAIL_ROTATE;
    ctrl.store_prev      = 1'b0;
    ctrl.edges.left_edge = slot_ext == first_slot;
    ctrl.edges.right_edge = slot == LAST_SLOT;
    ctrl.out_load        = 1'b0;
    ctrl.out_last        = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          // Drop the beat's column when the chain is full
          if (loaded < FULL_CNT) begin
            ctrl.shift    = 1'b1;
            ctrl.tail_sel = TAIL_LOAD;
            loaded_next   = loaded + CNT_W'(1);
          end
          if (s_tlast) begin
            slot_next   = '0;
            passes_next = '0;
            state_next  = (pass_count == '0) ? ST_EMIT : ST_SMOOTH;
          end
        end
      end
      ST_SMOOTH: begin
        ctrl.shift      = 1'b1;
        ctrl.tail_sel   = TAIL_RULE;
        ctrl.store_prev = 1'b1;
        if (slot == LAST_SLOT) begin
          slot_next   = '0;
          passes_next = passes + PASS_COUNT_W'(1);
          if (passes + PASS_COUNT_W'(1) == pass_count) begin
            state_next = ST_EMIT;
          end
        end else begin
          slot_next = slot + SLOT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl.shift    = 1'b1;
          ctrl.tail_sel = TAIL_ROTATE;
          ctrl.out_load = in_grid;
          ctrl.out_last = slot == LAST_SLOT;
          if (slot == LAST_SLOT) begin
            slot_next   = '0;
            loaded_next = '0;
            passes_next = '0;
            state_next  = ST_LOAD;
          end else begin
            slot_next = slot + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- rtl/core/cave_automaton_smoothing_top.sv -----
// Top level of the cave-smoothing automaton: column chain, rule unit,
// sequencer and output register. Depends on cavesm_pkg and all rtl/core modules.
//
// Columns stream in one per beat while the block is loading and shift into a
// chain of MAX_COLUMNS cells; the beat with tlast starts the run. Each smoothing
// pass rotates the whole chain once through a single rule unit, over all
// MAX_COLUMNS cells regardless of how many columns were loaded, and the
// results are then rotated out, one beat per cycle when the sink is ready.
// Columns beyond MAX_COLUMNS are dropped; rows at or above rows_in_use are
// stored and emitted as zero. Configuration writes are always accepted and
// must only be made while the block is idle.
module cave_automaton_smoothing_top
  import cavesm_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [COL_BITS-1:0]    s_tdata,   // [63:0] column_cells
  input  logic                   s_tlast,   // final_column
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [COL_BITS-1:0]    m_tdata,   // [63:0] result_cells
  output logic                   m_tlast,   // last_result
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ROWS_IN_USE_W-1:0] rows_in_use;
  logic [PASS_COUNT_W-1:0]  pass_count;
  logic [PASS_COUNT_W-1:0]  passes;
  logic [MAX_ROWS-1:0]      mask;
  logic [MAX_ROWS-1:0]      cell_q [MAX_COLUMNS];
  logic [MAX_ROWS-1:0]      tail_din;
  logic [MAX_ROWS-1:0]      prev_col;
  logic [MAX_ROWS-1:0]      rule_col;
  logic                     out_free;
  cavesm_ctrl_t             ctrl;
  cavesm_state_t            state;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_IN_USE_RST;
      pass_count  <= PASS_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWS_IN_USE_W-1:0];
        REG_PASS_COUNT:  pass_count  <= cfg_data[PASS_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Rows below the configured height belong to the grid
  always_comb begin
    for (int y = 0; y < MAX_ROWS; y++) begin
      mask[y] = ROWS_IN_USE_W'(y) < rows_in_use;
    end
  end

  // Sequencer
  assign out_free = !m_tvalid || m_tready;

  cavesm_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tlast   (s_tlast),
    .s_tready  (s_tready),
    .pass_count(pass_count),
    .out_free  (out_free),
    .ctrl      (ctrl),
    .state     (state),
    .passes    (passes)
  );

  // Select what enters the tail of the chain
  always_comb begin
    case (ctrl.tail_sel)
      TAIL_LOAD:   tail_din = s_tdata[MAX_ROWS-1:0] & mask;
      TAIL_RULE:   tail_din = rule_col;
      TAIL_ROTATE: tail_din = cell_q[0];
      default:     tail_din = cell_q[0];
    endcase
  end

  // Column chain: each cell takes from its right neighbor, the last from the tail
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_chain
    if (i == MAX_COLUMNS - 1) begin : g_tail
      cavesm_cell #(.ROWS(MAX_ROWS)) u_cell (
        .clk  (clk),
        .shift(ctrl.shift),
        .din  (tail_din),
        .q    (cell_q[i])
      );
    end else begin : g_body
      cavesm_cell #(.ROWS(MAX_ROWS)) u_cell (
        .clk  (clk),
        .shift(ctrl.shift),
        .din  (cell_q[i+1]),
        .q    (cell_q[i])
      );
    end
  end

  // Hold the old value of the column just updated as the next left neighbor
  always_ff @(posedge clk) begin
    if (ctrl.store_prev) begin
      prev_col <= cell_q[0];
    end
  end

  cavesm_rule #(
    .ROWS(MAX_ROWS)
  ) u_rule (
    .left_col  (prev_col),
    .center_col(cell_q[0]),
    .right_col (cell_q[1]),
    .mask      (mask),
    .edges     (ctrl.edges),
    .new_col   (rule_col)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= COL_BITS'(cell_q[0] & mask);
      m_tlast <= ctrl.out_last;
    end
  end

`ifndef ASSERT_OFF
  // Loading never happens outside the load phase
  a_load_phase: assert property (@(posedge clk) disable iff (rst)
    (ctrl.shift && ctrl.tail_sel == TAIL_LOAD) |-> state == ST_LOAD)
    else $error("column loaded outside the load phase");

  // Smoothing only runs while passes remain
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SMOOTH |-> passes < pass_count)
    else $error("smoothing beyond the configured pass count");

  // The last result beat ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && ctrl.out_last) |=> state == ST_LOAD)
    else $error("run did not end after the last column");

  // A new result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ----- verif/cavesm_checker.sv -----
// Checker for the cave-smoothing automaton: follows the register, input and
// output channels, predicts each smoothed column and compares beat by beat.
// Depends on cavesm_pkg.
`timescale 1ns / 100ps

module cavesm_checker
  import cavesm_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [COL_BITS-1:0]    s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [COL_BITS-1:0]    m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     columns_pending,
  output int                     columns_checked,
  output int                     grids_run
);

  typedef struct packed {
    logic [COL_BITS-1:0] cells;
    logic                last;
  } smoothed_col_t;

  // Predicted output columns, oldest first
  smoothed_col_t expected_cols[$];

  // Own copy of the grid store and the registers
  logic [COL_BITS-1:0]      cave [MAX_COLUMNS];
  int                       stored = 0;
  logic [ROWS_IN_USE_W-1:0] rows_reg = ROWS_IN_USE_RST;
  logic [PASS_COUNT_W-1:0]  passes_reg = PASS_COUNT_RST;

  int errors_seen = 0;
  int checked     = 0;
  int runs        = 0;

  // Height of the grid: rows_in_use saturated to the row limit
  function automatic int height();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic logic [COL_BITS-1:0] live_rows(input int h);
    if (h >= COL_BITS) return '1;
    return (COL_BITS'(1) << h) - COL_BITS'(1);
  endfunction

  // Cells outside the grid count as alive
  function automatic logic alive_at(input int x, input int y, input int w, input int h);
    if (x < 0 || x >= w || y < 0 || y >= h) return 1'b1;
    return cave[x][y];
  endfunction

  // One synchronous 4-5 rule update over the stored columns
  task automatic smooth_pass(input int w, input int h);
    logic [COL_BITS-1:0] next_cols [MAX_COLUMNS];
    int neighbors;
    for (int x = 0; x < w; x++) begin
      next_cols[x] = '0;
      for (int y = 0; y < h; y++) begin
        neighbors = 0;
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            if (dx != 0 || dy != 0) neighbors += alive_at(x + dx, y + dy, w, h);
        if (neighbors > KEEP_COUNT) next_cols[x][y] = 1'b1;
        else if (neighbors == KEEP_COUNT) next_cols[x][y] = cave[x][y];
      end
    end
    for (int x = 0; x < w; x++) cave[x] = next_cols[x];
  endtask

  // Smooth the stored grid and queue every column, last one marked
  task automatic run_grid();
    int h;
    logic [COL_BITS-1:0] mask;
    h = height();
    mask = live_rows(h);
    for (int x = 0; x < stored; x++) cave[x] &= mask;
    for (int p = 0; p < passes_reg; p++) smooth_pass(stored, h);
    for (int x = 0; x < stored; x++)
      expected_cols.push_back('{cells: cave[x] & mask, last: (x == stored - 1)});
    stored = 0;
    runs++;
  endtask

  always @(posedge clk) begin
    smoothed_col_t want;
    if (rst) begin
      expected_cols.delete();
      stored = 0;
      rows_reg = ROWS_IN_USE_RST;
      passes_reg = PASS_COUNT_RST;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_reg = cfg_data[ROWS_IN_USE_W-1:0];
          REG_PASS_COUNT:  passes_reg = cfg_data[PASS_COUNT_W-1:0];
          default: ;
        endcase
      end

      // Compare each output beat with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_cols.size() == 0) begin
          errors_seen++;
          $display("%0t: unexpected result beat: expected none, actual cells %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_cols.pop_front();
          checked++;
          if (m_tdata !== want.cells) begin
            errors_seen++;
            $display("%0t: result_cells mismatch: expected %h, actual %h",
                     $time, want.cells, m_tdata);
          end
          if (m_tlast !== want.last) begin
            errors_seen++;
            $display("%0t: last_result mismatch: expected %b, actual %b",
                     $time, want.last, m_tlast);
          end
        end
      end

      // Store input columns; drop them once the store is full
      if (s_tvalid && s_tready) begin
        if (stored < MAX_COLUMNS) begin
          cave[stored] = s_tdata & live_rows(height());
          stored++;
        end
        if (s_tlast) run_grid();
      end
    end

    mismatches      <= errors_seen;
    columns_pending <= expected_cols.size();
    columns_checked <= checked;
    grids_run       <= runs;
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the cave-smoothing automaton: clock, reset, column and
// register stimulus, sink back-pressure and the verdict.
// Depends on cavesm_pkg, cave_automaton_smoothing_top and cavesm_checker.
`timescale 1ns / 100ps

module tb_top;
  import cavesm_pkg::*;

  localparam int MAX_COLUMNS      = 64;
  localparam int MAX_ROWS         = 64;
  localparam int RANDOM_ITEMS     = 200;
  localparam int QUIET_AFTER      = 165;
  localparam int SETTLE_CYCLES    = 2 * MAX_COLUMNS + 32;
  localparam int SINK_HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef enum int {
    FILL_RANDOM,
    FILL_CAVE,
    FILL_SOLID,
    FILL_SPARSE
  } fill_style_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [COL_BITS-1:0]    s_tdata = '0;    // [63:0] column_cells
  logic                   s_tlast = 1'b0;  // final_column
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [COL_BITS-1:0]    m_tdata;         // [63:0] result_cells
  logic                   m_tlast;         // last_result
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ROWS_IN_USE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int columns_pending;
  int columns_checked;
  int grids_run;

  // Stimulus controls
  int   gap_pct        = 30;
  int   stall_pct      = 25;
  logic quiet          = 1'b0;
  int   hold_requests  = 0;
  int   items_sent     = 0;
  int   directed_items = 0;
  int   settings_used  = 0;
  int   phase_no       = 0;

  cave_automaton_smoothing_top #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) DUT (.*);

  cavesm_checker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) smoothing_check (.*);

  always #4 clk = ~clk;

  // Sink: random short stalls, plus a long hold on request
  initial begin : sink
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!rst && !quiet && $urandom_range(99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Give up if the run stops making progress
  initial begin : watchdog
    for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d columns still expected",
             $time, CYCLE_LIMIT, columns_pending);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [COL_BITS-1:0] make_column(input fill_style_t style);
    logic [COL_BITS-1:0] cells;
    cells = {$urandom, $urandom};
    case (style)
      FILL_CAVE:
        for (int y = 0; y < COL_BITS; y++) cells[y] = ($urandom_range(99) < 45);
      FILL_SOLID:
        cells = $urandom_range(1) ? '1 : '0;
      FILL_SPARSE: begin
        cells = '0;
        cells[$urandom_range(COL_BITS - 1)] = 1'b1;
        if ($urandom_range(1)) cells = ~cells;
      end
      default: ;
    endcase
    return cells;
  endfunction

  // Mostly narrow grids, some wide, a few near or beyond the store size
  function automatic int pick_width();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return $urandom_range(MAX_COLUMNS + 6, MAX_COLUMNS - 1);
    if (roll < 20) return $urandom_range(40, 13);
    return $urandom_range(12, 1);
  endfunction

  // Offer one column beat, with an optional gap first
  task automatic send_column(input logic [COL_BITS-1:0] cells, input logic last);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cells;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_grid(input int width, input fill_style_t style);
    for (int c = 0; c < width; c++) send_column(make_column(style), c == width - 1);
  endtask

  // Drop valid, drain all predicted columns, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (columns_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers in back-to-back beats
  task automatic configure(input logic [CFG_DATA_W-1:0] rows_val,
                           input logic [CFG_DATA_W-1:0] passes_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= rows_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_PASS_COUNT;
    cfg_data  <= passes_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One register setting followed by random grids
  task automatic run_setting(input logic [CFG_DATA_W-1:0] rows_val,
                             input logic [CFG_DATA_W-1:0] passes_val,
                             input int budget, input bit with_pressure);
    int sent;
    int width;
    settle();
    configure(rows_val, passes_val);
    gap_pct = ($urandom_range(2) == 0) ? 0 : 30;
    stall_pct <= (gap_pct == 0) ? 0 : 25;
    sent = 0;
    if (with_pressure) begin
      // Hold the sink through the run while the next grid is offered,
      // and overfill the store with that grid
      send_grid(20, FILL_CAVE);
      hold_requests <= hold_requests + 1;
      send_grid(MAX_COLUMNS + 2, FILL_RANDOM);
      sent = 20 + MAX_COLUMNS + 2;
    end
    while (sent < budget) begin
      width = pick_width();
      send_grid(width, fill_style_t'($urandom_range(3)));
      sent += width;
      if (!quiet && items_sent - directed_items >= QUIET_AFTER) quiet <= 1'b1;
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed grids at the reset settings
    send_column('1, 1'b1);
    send_column('0, 1'b1);
    send_column('0, 1'b0);
    send_column('1, 1'b1);
    send_column({32{2'b10}}, 1'b0);
    send_column({32{2'b01}}, 1'b0);
    send_column(64'h8000_0000_0000_0001, 1'b1);
    send_column(64'h1, 1'b0);
    send_column(64'h8000_0000_0000_0000, 1'b0);
    send_column('0, 1'b0);
    send_column('1, 1'b1);

    // No rows at all, and no passes
    settle();
    configure(8'd0, 8'd0);
    send_grid(3, FILL_RANDOM);

    // Single row over the longest run
    settle();
    configure(8'd1, 8'd255);
    send_grid(2, FILL_SOLID);

    // Height above the row limit, grid passed straight through
    settle();
    configure(8'd127, 8'd0);
    send_grid(4, FILL_RANDOM);
    directed_items = items_sent;

    // Random grids over a sequence of settings
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      case (phase_no)
        0: run_setting(8'd64, 8'd5, 30, 1'b1);
        1: run_setting(8'd1, 8'd0, 24, 1'b0);
        2: run_setting(8'd0, 8'd3, 16, 1'b0);
        3: run_setting(8'd127, 8'd255, 6, 1'b0);
        4: run_setting(8'd64, 8'd0, 24, 1'b0);
        5: run_setting(8'd2, 8'd1, 20, 1'b0);
        // top data bit lies outside the height register
        6: run_setting(8'hC0, 8'd4, 24, 1'b0);
        7: run_setting(8'd65, 8'd2, 20, 1'b0);
        8: run_setting(8'd63, 8'd7, 24, 1'b0);
        default: run_setting(CFG_DATA_W'($urandom_range(255)),
                             CFG_DATA_W'($urandom_range(10)), 24, 1'b0);
      endcase
      phase_no++;
    end

    settle();
    $display("Covered %0d input columns (%0d directed) in %0d grids over %0d settings",
             items_sent, directed_items, grids_run, settings_used);
    $display("Compared %0d smoothed columns, %0d mismatches", columns_checked, mismatches);
    if (mismatches == 0 && columns_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
